### design/fdl_pkg.sv
// Shared types and constants for the fractional delay line.
`default_nettype none

package fdl_pkg;

   // Ring geometry
   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = 11;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

   // Word fields
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W = 16;
   localparam int POS_W = 11;
   localparam int WORD_W = 2 * SAMPLE_W;

   // Remainder unit: signed position sum, one quotient bit per step
   localparam int DIV_W = IDX_W + 2;
   localparam int DCNT_W = $clog2(DIV_W);

   // Request codes
   localparam logic REQ_SHIFT = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_WRAP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_ADDR0,
      ST_ADDR1,
      ST_DATA1,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_BLEND_IM,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic div_step;
      logic wrap;
      logic rd_next;
      logic shift_wr;
      logic cap_a;
      logic cap_b;
      logic mul;
      logic mul_im;
      logic blend_re;
      logic blend_im;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic is_read;
   } status_type;

endpackage

`default_nettype wire

### design/fdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/fdl_ctrl.sv
// Sequencing state machine for the fractional delay line.
`default_nettype none

module fdl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire fdl_pkg::status_type status,
   output fdl_pkg::cmd_type         cmd
);

   import fdl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            state_in = status.is_read ? ST_ADDR0 : ST_SHIFT_RD;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = ST_DONE;
         ST_ADDR0:    state_in = ST_ADDR1;
         ST_ADDR1:    state_in = ST_DATA1;
         ST_DATA1:    state_in = ST_MUL_RE;
         ST_MUL_RE:   state_in = ST_MUL_IM;
         ST_MUL_IM:   state_in = ST_BLEND_IM;
         ST_BLEND_IM: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:    cmd.clr_step = 1'b1;
         ST_IDLE:     cmd.accept = accept;
         ST_DIVIDE:   cmd.div_step = 1'b1;
         ST_WRAP:     cmd.wrap = 1'b1;
         ST_SHIFT_WR: cmd.shift_wr = 1'b1;
         ST_ADDR1: begin
            cmd.rd_next = 1'b1;
            cmd.cap_a = 1'b1;
         end
         ST_DATA1:    cmd.cap_b = 1'b1;
         ST_MUL_RE:   cmd.mul = 1'b1;
         ST_MUL_IM: begin
            cmd.mul = 1'b1;
            cmd.mul_im = 1'b1;
            cmd.blend_re = 1'b1;
         end
         ST_BLEND_IM: cmd.blend_im = 1'b1;
         ST_DONE:     cmd.load_out = out_free;
         default:     cmd = '0;
      endcase
   end

   // Hold the result word until the consumer takes it
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/fdl_datapath.sv
// Ring store, index wrap unit and interpolator for the fractional delay line.
`default_nettype none

module fdl_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fdl_pkg::cmd_type                    cmd,
   output fdl_pkg::status_type                      status,
   input  wire logic                                csr_wr_en,
   input  wire logic [fdl_pkg::LEN_W-1:0]           csr_wr_data,
   input  wire logic                                req_type,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] req_sample_re,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] req_sample_im,
   input  wire logic signed [fdl_pkg::POS_W-1:0]    req_position_int,
   input  wire logic [fdl_pkg::FRAC_W-1:0]          req_position_frac,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]      rsp_result_re,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]      rsp_result_im
);

   import fdl_pkg::*;

   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int ACC_W = PROD_W + 1;
   localparam int Q_W = ACC_W - FRAC_W;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((1 <<< (SAMPLE_W - 1)) - 1);
   localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(1 <<< (SAMPLE_W - 1));

   // Round a weighted sum to nearest (ties up) and saturate to a sample
   function automatic logic signed [SAMPLE_W-1:0] blend_round(
      input logic signed [SAMPLE_W-1:0] lo,
      input logic signed [PROD_W-1:0]   prod
   );
      logic signed [ACC_W-1:0] acc;
      logic signed [Q_W-1:0]   q;
      logic signed [SAMPLE_W-1:0] res;
      acc = {{(ACC_W-SAMPLE_W-FRAC_W){lo[SAMPLE_W-1]}}, lo, {FRAC_W{1'b0}}}
            + {prod[PROD_W-1], prod} + ROUND_HALF;
      q = acc[ACC_W-1:FRAC_W];
      if (q > SAT_MAX) begin
         res = SAT_MAX[SAMPLE_W-1:0];
      end else if (q < SAT_MIN) begin
         res = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // Configuration and ring position
   logic [LEN_W-1:0] csr_len_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] clr_addr_ff;

   // Latched request
   logic                       is_read_ff;
   logic signed [SAMPLE_W-1:0] new_re_ff, new_im_ff;
   logic [FRAC_W-1:0]          frac_ff;
   logic [LEN_W-1:0]           n_ff, n_eff;

   // Remainder unit
   logic [DIV_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [IDX_W-1:0]  rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [DIV_W-1:0]  pos_sum;
   logic [LEN_W-1:0]  rem_sh;
   logic [LEN_W-1:0]  rem_sub;
   logic [LEN_W-1:0]  wrap_diff;
   logic [IDX_W-1:0]  idx_ff, idx1;
   logic [LEN_W-1:0]  idx_inc;

   // Store access
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   // Interpolator
   logic signed [SAMPLE_W-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [DIFF_W-1:0]   d_re, d_im, d_sel;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [SAMPLE_W-1:0] wr_re_ff, wr_im_ff;
   logic signed [SAMPLE_W-1:0] out_re_ff, out_im_ff;

   // Clamp the configured length to the ring
   always_comb begin
      n_eff = csr_len_ff;
      if (csr_len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (csr_len_ff > LEN_W'(DEPTH)) begin
         n_eff = LEN_W'(DEPTH);
      end
   end

   // Unwrapped index: head plus one, or position plus head
   always_comb begin
      if (req_type == REQ_READ) begin
         pos_sum = {{(DIV_W-POS_W){req_position_int[POS_W-1]}}, req_position_int}
                   + {{(DIV_W-IDX_W){1'b0}}, head_ff};
      end else begin
         pos_sum = {{(DIV_W-IDX_W){1'b0}}, head_ff} + DIV_W'(1);
      end
   end

   // One remainder bit per step
   assign rem_sh = {rem_ff, mag_ff[DIV_W-1]};
   assign rem_sub = rem_sh - n_ff;
   assign wrap_diff = n_ff - {1'b0, rem_ff};

   // Neighbor entry for the ceiling tap
   assign idx_inc = {1'b0, idx_ff} + LEN_W'(1);
   always_comb begin
      if (frac_ff == '0) begin
         idx1 = idx_ff;
      end else if (idx_inc == n_ff) begin
         idx1 = '0;
      end else begin
         idx1 = idx_inc[IDX_W-1:0];
      end
   end

   assign status.clr_last = (clr_addr_ff == IDX_W'(DEPTH - 1));
   assign status.div_last = (dcnt_ff == '0);
   assign status.is_read = is_read_ff;

   // Store port selection
   assign ram_we = cmd.clr_step || cmd.shift_wr;
   assign ram_waddr = cmd.clr_step ? clr_addr_ff : idx_ff;
   assign ram_wdata = cmd.clr_step ? '0 : {new_im_ff, new_re_ff};
   assign ram_raddr = cmd.rd_next ? idx1 : idx_ff;

   fdl_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Tap differences and shared multiplier operand
   assign d_re = {b_re_ff[SAMPLE_W-1], b_re_ff} - {a_re_ff[SAMPLE_W-1], a_re_ff};
   assign d_im = {b_im_ff[SAMPLE_W-1], b_im_ff} - {a_im_ff[SAMPLE_W-1], a_im_ff};
   assign d_sel = cmd.mul_im ? d_im : d_re;

   assign head_in = cmd.shift_wr ? idx_ff : head_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= LEN_RESET;
         head_ff <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            csr_len_ff <= csr_wr_data;
         end
         head_ff <= head_in;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
      end
   end

   // Latch the request and load the remainder unit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_read_ff <= req_type;
         new_re_ff <= req_sample_re;
         new_im_ff <= req_sample_im;
         frac_ff <= req_position_frac;
         n_ff <= n_eff;
         neg_ff <= pos_sum[DIV_W-1];
         mag_ff <= pos_sum[DIV_W-1] ? -pos_sum : pos_sum;
         rem_ff <= '0;
         dcnt_ff <= DCNT_W'(DIV_W - 1);
      end else if (cmd.div_step) begin
         mag_ff <= mag_ff << 1;
         rem_ff <= (rem_sh >= n_ff) ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
   end

   // Euclidean fix-up of a negative position
   always_ff @(posedge clock) begin
      if (cmd.wrap) begin
         idx_ff <= (neg_ff && rem_ff != '0) ? wrap_diff[IDX_W-1:0] : rem_ff;
      end
   end

   // Capture taps, multiply, round, and register the displaced and output words
   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         a_re_ff <= ram_rdata[SAMPLE_W-1:0];
         a_im_ff <= ram_rdata[WORD_W-1:SAMPLE_W];
      end
      if (cmd.cap_b) begin
         b_re_ff <= ram_rdata[SAMPLE_W-1:0];
         b_im_ff <= ram_rdata[WORD_W-1:SAMPLE_W];
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(d_sel * $signed({1'b0, frac_ff}));
      end
      if (cmd.shift_wr) begin
         wr_re_ff <= ram_rdata[SAMPLE_W-1:0];
         wr_im_ff <= ram_rdata[WORD_W-1:SAMPLE_W];
      end
      if (cmd.blend_re) begin
         wr_re_ff <= blend_round(a_re_ff, prod_ff);
      end
      if (cmd.blend_im) begin
         wr_im_ff <= blend_round(a_im_ff, prod_ff);
      end
      if (cmd.load_out) begin
         out_re_ff <= wr_re_ff;
         out_im_ff <= wr_im_ff;
      end
   end

   assign rsp_result_re = out_re_ff;
   assign rsp_result_im = out_im_ff;

endmodule

`default_nettype wire

### design/fractional_delay_line_top.sv
// Top level of the fractional delay line: controller plus datapath.
`default_nettype none

// A ring of 1024 complex Q1.15 samples, of which csr_wr_data sets how many are
// in use (0 acts as 1, above 1024 acts as 1024). A shift word (req_type 0)
// advances the head, returns the sample it displaces and stores the new one; a
// read word (req_type 1) returns the sample linearly interpolated at
// head + position_int + position_frac/65536, wrapped into the ring, rounded to
// nearest and saturated. Every word gives one result word. After reset the
// block zeroes the whole ring and takes no word meanwhile; the length
// register can still be written. A word then runs through the 12-step
// remainder unit that wraps the index; a read also fetches its two taps in
// turn through the single store read port and forms its two products in turn
// on the shared multiplier. One word is in flight at a time; the finished
// result sits in an output register so the next word is taken while it waits.
module fractional_delay_line_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [fdl_pkg::LEN_W-1:0]           csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] req_sample_re,
   input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] req_sample_im,
   input  wire logic signed [fdl_pkg::POS_W-1:0]    req_position_int,
   input  wire logic [fdl_pkg::FRAC_W-1:0]          req_position_frac,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]      rsp_result_re,
   output logic signed [fdl_pkg::SAMPLE_W-1:0]      rsp_result_im
);

   import fdl_pkg::*;

   cmd_type    cmd;
   status_type status;

   fdl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   fdl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_type         (req_type),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .req_position_int (req_position_int),
      .req_position_frac(req_position_frac),
      .rsp_result_re    (rsp_result_re),
      .rsp_result_im    (rsp_result_im)
   );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the fractional delay line: ring tracker, stimulus and checks.

module tb_top;
   import fdl_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_WORDS = 135;
   localparam int PHASE_COUNT = 9;

   // Track the ring contents and predict every result word in order
   class ring_tracker;
      logic [WORD_W-1:0] ring [DEPTH];
      int unsigned head;
      logic [LEN_W-1:0] length;
      logic [WORD_W-1:0] pending_samples[$];
      int mismatches;
      int shifts_seen;
      int reads_seen;
      int results_checked;

      function new();
         for (int i = 0; i < DEPTH; i++) ring[i] = '0;
         head = 0;
         length = LEN_RESET;
         mismatches = 0;
         shifts_seen = 0;
         reads_seen = 0;
         results_checked = 0;
      endfunction

      // Zero acts as one entry, anything past the ring as the whole ring
      function int unsigned live_length();
         if (length == 0) return 1;
         if (length > DEPTH) return DEPTH;
         return length;
      endfunction

      function int unsigned wrap(int v, int unsigned n);
         int m;
         m = v % int'(n);
         if (m < 0) m += int'(n);
         return m;
      endfunction

      // Weighted sum floor*(1-f) + ceil*f, round half up, clamp to Q1.15
      function logic [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] lo,
                                          logic signed [SAMPLE_W-1:0] hi,
                                          logic [FRAC_W-1:0] frac);
         longint acc;
         longint q;
         acc = longint'(lo) * (longint'(65536) - longint'(frac))
               + longint'(hi) * longint'(frac) + 32768;
         q = acc >>> 16;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[SAMPLE_W-1:0];
      endfunction

      function void take_word(logic kind, logic [SAMPLE_W-1:0] s_re,
                              logic [SAMPLE_W-1:0] s_im,
                              logic signed [POS_W-1:0] pos_int,
                              logic [FRAC_W-1:0] pos_frac);
         int unsigned n;
         int unsigned i0;
         int unsigned i1;
         logic [WORD_W-1:0] a;
         logic [WORD_W-1:0] b;
         n = live_length();
         if (kind == REQ_SHIFT) begin
            // Advance the head, hand back what sits there, store the new sample
            head = wrap(int'(head) + 1, n);
            pending_samples.push_back(ring[head]);
            ring[head] = {s_im, s_re};
            shifts_seen++;
         end else begin
            i0 = wrap(int'(pos_int) + int'(head), n);
            i1 = (pos_frac != 0) ? wrap(int'(pos_int) + 1 + int'(head), n) : i0;
            a = ring[i0];
            b = ring[i1];
            pending_samples.push_back({blend(a[31:16], b[31:16], pos_frac),
                                       blend(a[15:0], b[15:0], pos_frac)});
            reads_seen++;
         end
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] got_re, logic [SAMPLE_W-1:0] got_im);
         logic [WORD_W-1:0] want;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result word re=%0d im=%0d with no word pending",
                        $signed(got_re), $signed(got_im));
            return;
         end
         want = pending_samples.pop_front();
         results_checked++;
         if (got_re !== want[15:0] || got_im !== want[31:16]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d: re exp %0d got %0d, im exp %0d got %0d",
                        results_checked, $signed(want[15:0]), $signed(got_re),
                        $signed(want[31:16]), $signed(got_im));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic req_type;
   logic signed [SAMPLE_W-1:0] req_sample_re;
   logic signed [SAMPLE_W-1:0] req_sample_im;
   logic signed [POS_W-1:0] req_position_int;
   logic [FRAC_W-1:0] req_position_frac;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_result_re;
   logic signed [SAMPLE_W-1:0] rsp_result_im;

   ring_tracker tracker;
   bit idling_on;
   int stall_left;
   int cycle_count;
   int length_writes;

   fractional_delay_line_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .req_position_int (req_position_int),
      .req_position_frac(req_position_frac),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_re    (rsp_result_re),
      .rsp_result_im    (rsp_result_im)
   );

   always #5 clock = ~clock;

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: cycle limit reached with %0d results outstanding",
                  tracker.pending_samples.size());
         $display("fractional_delay_line_top test failed");
         $finish;
      end
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Note accepted words and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.take_word(req_type, req_sample_re, req_sample_im,
                              req_position_int, req_position_frac);
         if (rsp_valid && !rsp_stall)
            tracker.check_sample(rsp_result_re, rsp_result_im);
      end
   end

   // Present one word, with an optional idle burst first, and hold it until taken
   task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] s_re,
                            input logic [SAMPLE_W-1:0] s_im,
                            input logic [POS_W-1:0] pos_int,
                            input logic [FRAC_W-1:0] pos_frac);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample_re <= s_re;
      req_sample_im <= s_im;
      req_position_int <= pos_int;
      req_position_frac <= pos_frac;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_shift(input logic [SAMPLE_W-1:0] s_re, input logic [SAMPLE_W-1:0] s_im);
      send_word(REQ_SHIFT, s_re, s_im, POS_W'($urandom), FRAC_W'($urandom));
   endtask

   task automatic send_read(input logic [POS_W-1:0] pos_int, input logic [FRAC_W-1:0] pos_frac);
      send_word(REQ_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom), pos_int, pos_frac);
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_samples.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.length = value;
      length_writes++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Mostly positions within one ring length either side, some anywhere in the field
   function automatic logic [POS_W-1:0] pick_position(int unsigned n);
      int p;
      if ($urandom_range(0, 9) < 7) begin
         p = int'($urandom_range(0, 2 * n)) - int'(n);
         if (p > 1023) p = 1023;
         if (p < -1024) p = -1024;
         return p[POS_W-1:0];
      end
      return POS_W'($urandom);
   endfunction

   function automatic logic [FRAC_W-1:0] pick_fraction();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return 16'hFFFF;
         3: return 16'h8000;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] phase_length(int phase);
      case (phase)
         0: return LEN_W'(DEPTH);
         1: return LEN_W'(2);
         2: return LEN_W'($urandom_range(3, 40));
         3: return LEN_W'(2047);
         4: return LEN_W'(1);
         5: return LEN_W'($urandom_range(41, 1023));
         6: return LEN_W'(0);
         7: return LEN_W'($urandom_range(1025, 2046));
         default: return LEN_W'($urandom_range(3, DEPTH));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_type = REQ_SHIFT;
      req_sample_re = '0;
      req_sample_im = '0;
      req_position_int = '0;
      req_position_frac = '0;
      rsp_stall = 1'b0;
      stall_left = 0;
      cycle_count = 0;
      length_writes = 0;
      idling_on = 1'b1;
      tracker = new();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: cleared ring, field extremes, rounding ties
      send_read(11'sd0, 16'd0);
      send_shift(16'h7FFF, 16'h8000);
      send_shift(16'h8000, 16'h7FFF);
      send_shift(16'hFFFF, 16'h0001);
      send_shift(16'h5555, 16'hAAAA);
      send_shift(16'hAAAA, 16'h5555);
      send_read(11'sd0, 16'd0);
      send_read(-11'sd1, 16'h8000);
      send_read(-11'sd2, 16'd1);
      send_read(-11'sd1, 16'hFFFF);
      send_read(11'h400, 16'd12345);
      send_read(11'sd1023, 16'hFFFF);
      send_read(-11'sd5, 16'h5555);

      // Shrink below the head so the next access wraps it
      write_length(LEN_W'(3));
      send_read(11'sd0, 16'd40000);
      send_shift(16'h1234, 16'hEDCB);
      send_read(-11'sd1, 16'd0);

      // Zero length behaves as a single entry
      write_length(LEN_W'(0));
      send_shift(16'd1234, 16'hEF1F);
      send_read(11'h400, 16'hFFFF);
      send_read(11'sd1023, 16'd1);

      // Oversized lengths clamp to the full ring, with a single-entry length between
      write_length(LEN_W'(2047));
      send_shift(16'h7FFF, 16'h7FFF);
      send_read(-11'sd1, 16'h8000);
      write_length(LEN_W'(1));
      send_shift(16'h8000, 16'h8000);
      send_read(11'sd0, 16'hFFFF);
      write_length(LEN_W'(1025));
      send_read(-11'sd1023, 16'h0001);

      // Random phases, each under its own length setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_length(phase_length(phase));
         idling_on = (phase == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            // In phase 2 only, hold off mid-phase until the block has emptied
            if (phase == 2 && k == PHASE_WORDS / 2) drain();
            if ($urandom_range(0, 99) < 55)
               send_shift(pick_sample(), pick_sample());
            else
               send_read(pick_position(tracker.live_length()), pick_fraction());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d shifts and %0d reads under %0d length settings,",
               tracker.shifts_seen, tracker.reads_seen, length_writes);
      $display("%0d results checked, %0d mismatches.",
               tracker.results_checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_samples.size() == 0) begin
         $display("fractional_delay_line_top test passed");
      end else begin
         if (tracker.pending_samples.size() != 0)
            $display("ERROR: %0d results never arrived", tracker.pending_samples.size());
         $display("fractional_delay_line_top test failed");
      end
      $finish;
   end

endmodule

### files.f
design/fdl_pkg.sv
design/fdl_ram.sv
design/fdl_ctrl.sv
design/fdl_datapath.sv
design/fractional_delay_line_top.sv
test/tb_top.sv
